// File: src/lse_pkg.sv
// Shared types and constants of the LSB steganography embedder.
`timescale 1ns / 1ps
`default_nettype none

package lse_pkg;

    // Fixed geometry of the frame.
    localparam int HEADER_BYTES = 54;
    localparam int MAGIC_CHARS  = 2;
    localparam int MAGIC_BITS   = MAGIC_CHARS * 8;

    // Position counter covers up to 2^32 - 1 secret bytes of eight bits.
    localparam int POS_W = 35;
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 56;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC_WORD  = 2'd0,
        CFG_EXT_LEN     = 2'd1,
        CFG_EXT_WORD    = 2'd2,
        CFG_SECRET_SIZE = 2'd3
    } cfg_idx_t;

    // Item kinds.
    localparam logic KIND_CARRIER = 1'b0;
    localparam logic KIND_SECRET  = 1'b1;

    // Status codes of a result beat.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_STARVED = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    // Phase codes as they appear on the result channel.
    localparam logic [2:0] PHASE_CODE_HEADER = 3'd0;
    localparam logic [2:0] PHASE_CODE_MAGIC  = 3'd1;
    localparam logic [2:0] PHASE_CODE_EXTLEN = 3'd2;
    localparam logic [2:0] PHASE_CODE_EXT    = 3'd3;
    localparam logic [2:0] PHASE_CODE_SIZE   = 3'd4;
    localparam logic [2:0] PHASE_CODE_DATA   = 3'd5;
    localparam logic [2:0] PHASE_CODE_TAIL   = 3'd6;

    // Embedding phases, one-hot.
    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_MAGIC  = 7'b0000010,
        PH_EXTLEN = 7'b0000100,
        PH_EXT    = 7'b0001000,
        PH_SIZE   = 7'b0010000,
        PH_DATA   = 7'b0100000,
        PH_TAIL   = 7'b1000000
    } phase_t;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] magic_word;
        logic [2:0]  ext_len;
        logic [55:0] ext_word;
        logic [31:0] secret_size;
    } cfg_t;

    // Payload of one input beat.
    typedef struct packed {
        logic       kind;
        logic [7:0] carrier_byte;
        logic [7:0] secret_byte;
    } item_t;

    // Payload of one result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] phase_now;
        logic [1:0] status;
        logic       payload_done;
    } result_t;

endpackage

`default_nettype wire

// File: src/lse_ifs.sv
// Valid/ready channel interfaces for input items and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface lse_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] carrier_byte;
    logic [7:0] secret_byte;

    modport source (output valid, output kind, output carrier_byte, output secret_byte,
                    input ready);
    modport sink   (input valid, input kind, input carrier_byte, input secret_byte,
                    output ready);
endinterface

interface lse_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] phase_now;
    logic [1:0] status;
    logic       payload_done;

    modport source (output valid, output out_byte, output byte_valid, output phase_now,
                    output status, output payload_done, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input phase_now,
                    input status, input payload_done, output ready);
endinterface

`default_nettype wire

// File: src/lsb_stego_embedder_unit.sv
// Top level of the LSB steganography embedder.
//
// Usage: carrier image bytes and secret byte loads arrive as beats on the
// item channel (kind 0 carrier, kind 1 secret load). Every item beat yields
// exactly one result beat on the result channel; carrier beats give the
// output image byte with byte_valid set, secret loads give byte_valid clear.
// The first 54 carrier bytes pass unchanged, then the frame (magic, extension
// length, extension, size, secret data) goes one bit per carrier byte into
// the LSB, after which carrier bytes pass unchanged again.
// Throughput is one item per clock while the result receiver keeps up; the
// phase update, holding register and bit insertion are one combinational pass
// between the input register and the result register. An accepted item moves
// from the input register into the result register, which offers it on the
// result channel; a result stall keeps it in the input register. When the
// result receiver stalls, the result register holds its beat and the input
// register absorbs one more item before item.ready drops. Reset empties both
// registers, returns to the header phase, empties the secret holding register
// and loads the configuration defaults. The configuration port must be written
// only while no item is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module lsb_stego_embedder_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lse_item_if.sink                            item,
    lse_result_if.source                        result,
    input  wire logic                           cfg_we,
    input  wire logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lse_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lse_pkg::*;

    cfg_t    cfg;
    item_t   held;
    result_t core_result;
    logic    pending;
    logic    space;
    logic    advance;

    // An item moves from the input register into the result register.
    assign advance = pending && space;

    lse_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lse_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .pending (pending),
        .held    (held)
    );

    lse_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (held),
        .cfg    (cfg),
        .result (core_result)
    );

    lse_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .data   (core_result),
        .space  (space),
        .result (result)
    );

endmodule

`default_nettype wire

// File: src/lse_cfg_regs.sv
// Configuration registers of the embedder, written through a plain write port.
`timescale 1ns / 1ps
`default_nettype none

module lse_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lse_pkg::CFG_DATA_W-1:0] cfg_data,
    output lse_pkg::cfg_t                       cfg
);
    import lse_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and replace the addressed field.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAGIC_WORD:  cfg_next.magic_word  = cfg_data[15:0];
                CFG_EXT_LEN:     cfg_next.ext_len     = cfg_data[2:0];
                CFG_EXT_WORD:    cfg_next.ext_word    = cfg_data[55:0];
                CFG_SECRET_SIZE: cfg_next.secret_size = cfg_data[31:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Registers reset to their documented defaults; the extension length starts at four.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word  <= '0;
            cfg_reg.ext_len     <= 3'd4;
            cfg_reg.ext_word    <= '0;
            cfg_reg.secret_size <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/lse_in_stage.sv
// Input register of the embedder: captures one item beat per cycle while it is empty or being drained.
`timescale 1ns / 1ps
`default_nettype none

module lse_in_stage (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lse_item_if.sink      item,
    input  wire logic     advance,
    output logic          pending,
    output lse_pkg::item_t held
);
    import lse_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // The register takes a new beat whenever it is empty or being drained.
    assign item.ready = !valid_reg || advance;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (item.ready)
        begin
            valid_next = item.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{kind: item.kind, carrier_byte: item.carrier_byte,
                          secret_byte: item.secret_byte};
        end
    end

    assign pending = valid_reg;
    assign held    = item_reg;

endmodule

`default_nettype wire

// File: src/lse_core.sv
// Embedding datapath: phase tracking, secret holding register and bit insertion.
`timescale 1ns / 1ps
`default_nettype none

module lse_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire lse_pkg::item_t item,
    input  wire lse_pkg::cfg_t  cfg,
    output lse_pkg::result_t    result
);
    import lse_pkg::*;

    // A chain of skips never passes more than two phases, plus one for the step itself.
    localparam int SETTLE_PASSES = 3;

    typedef struct packed {
        phase_t           phase;
        logic [POS_W-1:0] pos;
    } pstate_t;

    // Length of a phase in carrier bytes.
    function automatic logic [POS_W-1:0] phase_len(input phase_t p, input cfg_t c);
        logic [POS_W-1:0] len;
        len = '0;
        unique case (p)
            PH_HEADER: len = POS_W'(HEADER_BYTES);
            PH_MAGIC:  len = POS_W'(MAGIC_BITS);
            PH_EXTLEN: len = POS_W'(32);
            PH_EXT:    len = POS_W'({c.ext_len, 3'b000});
            PH_SIZE:   len = POS_W'(32);
            PH_DATA:   len = {c.secret_size, 3'b000};
            PH_TAIL:   len = '0;
            default:   len = '0;
        endcase
        return len;
    endfunction

    function automatic phase_t phase_succ(input phase_t p);
        phase_t n;
        n = PH_TAIL;
        unique case (p)
            PH_HEADER: n = PH_MAGIC;
            PH_MAGIC:  n = PH_EXTLEN;
            PH_EXTLEN: n = PH_EXT;
            PH_EXT:    n = PH_SIZE;
            PH_SIZE:   n = PH_DATA;
            default:   n = PH_TAIL;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] phase_code(input phase_t p);
        logic [2:0] code;
        code = PHASE_CODE_TAIL;
        unique case (p)
            PH_HEADER: code = PHASE_CODE_HEADER;
            PH_MAGIC:  code = PHASE_CODE_MAGIC;
            PH_EXTLEN: code = PHASE_CODE_EXTLEN;
            PH_EXT:    code = PHASE_CODE_EXT;
            PH_SIZE:   code = PHASE_CODE_SIZE;
            PH_DATA:   code = PHASE_CODE_DATA;
            default:   code = PHASE_CODE_TAIL;
        endcase
        return code;
    endfunction

    // Move past every phase whose length is already used up, including empty ones.
    function automatic pstate_t settle(input pstate_t s, input cfg_t c);
        pstate_t r;
        r = s;
        for (int i = 0; i < SETTLE_PASSES; i++)
        begin
            if (r.phase != PH_TAIL && r.pos >= phase_len(r.phase, c))
            begin
                r.phase = phase_succ(r.phase);
                r.pos   = '0;
            end
        end
        return r;
    endfunction

    // Frame bit of the header words, MSB first; pos is below the phase length.
    function automatic logic frame_bit(input phase_t p, input logic [POS_W-1:0] pos,
                                       input cfg_t c);
        logic       b;
        logic [3:0] magic_idx;
        logic [4:0] word_idx;
        logic [5:0] ext_idx;
        b         = 1'b0;
        magic_idx = 4'(MAGIC_BITS - 1) - pos[3:0];
        word_idx  = ~pos[4:0];
        ext_idx   = {c.ext_len, 3'b000} - 6'd1 - pos[5:0];
        unique case (p)
            PH_MAGIC:  b = c.magic_word[magic_idx];
            PH_EXTLEN: b = (word_idx < 5'd3) ? c.ext_len[word_idx[1:0]] : 1'b0;
            PH_EXT:    b = c.ext_word[ext_idx];
            PH_SIZE:   b = c.secret_size[word_idx];
            default:   b = 1'b0;
        endcase
        return b;
    endfunction

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       hold_byte_reg, hold_byte_next;
    logic             hold_full_reg, hold_full_next;

    pstate_t          start_st;
    pstate_t          end_st;
    logic [POS_W-1:0] pos_step;
    logic [POS_W-1:0] pos_inc;
    logic [7:0]       ob;
    logic             ob_valid;
    logic [1:0]       stat;

    // Handle one item against the state as settled at the start of the step.
    always_comb
    begin
        start_st       = settle('{phase: phase_reg, pos: pos_reg}, cfg);
        pos_inc        = start_st.pos + POS_ONE;
        pos_step       = start_st.pos;
        hold_byte_next = hold_byte_reg;
        hold_full_next = hold_full_reg;
        ob             = 8'd0;
        ob_valid       = 1'b0;
        stat           = STATUS_OK;

        if (item.kind == KIND_SECRET)
        begin
            // Secret load: taken only into an empty holding register.
            if (hold_full_reg)
            begin
                stat = STATUS_DROPPED;
            end
            else
            begin
                hold_byte_next = item.secret_byte;
                hold_full_next = 1'b1;
            end
        end
        else
        begin
            ob_valid = 1'b1;
            unique case (start_st.phase)
                PH_HEADER:
                begin
                    ob       = item.carrier_byte;
                    pos_step = pos_inc;
                end
                PH_TAIL:
                begin
                    ob = item.carrier_byte;
                end
                PH_DATA:
                begin
                    if (!hold_full_reg)
                    begin
                        ob   = item.carrier_byte;
                        stat = STATUS_STARVED;
                    end
                    else
                    begin
                        ob       = {item.carrier_byte[7:1], hold_byte_reg[~start_st.pos[2:0]]};
                        pos_step = pos_inc;
                        // The held byte is released after its last bit.
                        if (pos_inc[2:0] == 3'd0)
                        begin
                            hold_full_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    ob       = {item.carrier_byte[7:1],
                                frame_bit(start_st.phase, start_st.pos, cfg)};
                    pos_step = pos_inc;
                end
            endcase
        end

        end_st = settle('{phase: start_st.phase, pos: pos_step}, cfg);

        phase_next = phase_reg;
        pos_next   = pos_reg;
        if (step)
        begin
            phase_next = end_st.phase;
            pos_next   = end_st.pos;
        end
        else
        begin
            hold_byte_next = hold_byte_reg;
            hold_full_next = hold_full_reg;
        end
    end

    // Result of the step in progress, registered by the output stage.
    assign result = '{out_byte: ob, byte_valid: ob_valid, phase_now: phase_code(start_st.phase),
                      status: stat, payload_done: (end_st.phase == PH_TAIL)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            hold_byte_reg <= 8'd0;
            hold_full_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            hold_byte_reg <= hold_byte_next;
            hold_full_reg <= hold_full_next;
        end
    end

endmodule

`default_nettype wire

// File: src/lse_out_stage.sv
// Result register of the embedder, drained by the result channel.
`timescale 1ns / 1ps
`default_nettype none

module lse_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire lse_pkg::result_t data,
    output logic                  space,
    lse_result_if.source          result
);
    import lse_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can take a beat when empty or when its beat leaves this cycle.
    assign space = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign result.valid        = valid_reg;
    assign result.out_byte     = data_reg.out_byte;
    assign result.byte_valid   = data_reg.byte_valid;
    assign result.phase_now    = data_reg.phase_now;
    assign result.status       = data_reg.status;
    assign result.payload_done = data_reg.payload_done;

endmodule

`default_nettype wire

// File: sim/lsb_stego_embedder_unit_tb.sv
// Self-checking testbench for the LSB steganography embedder top level.
`timescale 1ns / 1ps

module lsb_stego_embedder_unit_tb;

    import lse_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lse_item_if   item_bus ();
    lse_result_if result_bus ();

    lsb_stego_embedder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the configuration registers, at their reset values.
    logic [15:0] magic_cfg    = '0;
    logic [2:0]  ext_len_cfg  = 3'd4;
    logic [55:0] ext_word_cfg = '0;
    logic [31:0] size_cfg     = '0;

    // Shadow copy of the embedding state.
    logic [2:0]        frame_phase = PHASE_CODE_HEADER;
    longint unsigned   frame_pos   = 0;
    logic [7:0]        held_secret = '0;
    logic              held_full   = 1'b0;

    // Beats waiting to be driven and result beats waiting to be seen.
    item_t   stream_in_q[$];
    result_t image_out_q[$];

    logic item_taken    = 1'b0;
    bit   mismatch_seen = 1'b0;
    bit   steady        = 1'b0;
    int   send_gap      = 0;
    int   recv_gap      = 0;
    int   hold_asked    = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog for a hung run.
    initial
    begin
        #4_000_000;
        $display("FAIL lsb_stego_embedder_unit");
        $finish;
    end

    // Idle length for either side: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Number of bytes or bits in a phase under the current configuration.
    function automatic longint unsigned phase_span(logic [2:0] p);
        case (p)
            PHASE_CODE_HEADER:                 return HEADER_BYTES;
            PHASE_CODE_MAGIC:                  return MAGIC_BITS;
            PHASE_CODE_EXTLEN, PHASE_CODE_SIZE: return 32;
            PHASE_CODE_EXT:                    return 64'(ext_len_cfg) << 3;
            PHASE_CODE_DATA:                   return 64'(size_cfg) << 3;
            default:                           return 0;
        endcase
    endfunction

    // Move past every phase that is empty or already complete.
    function automatic void skip_done_phases();
        while (frame_phase < PHASE_CODE_TAIL && frame_pos >= phase_span(frame_phase))
        begin
            frame_phase++;
            frame_pos = 0;
        end
        if (frame_phase >= PHASE_CODE_TAIL)
        begin
            frame_phase = PHASE_CODE_TAIL;
            frame_pos   = 0;
        end
    endfunction

    // Header word bit for the magic, length, extension and size fields, MSB first.
    function automatic logic frame_bit(logic [2:0] p, longint unsigned pos);
        longint unsigned sh;
        logic [63:0]     word;
        sh = phase_span(p) - 1 - pos;
        case (p)
            PHASE_CODE_MAGIC:  word = 64'(magic_cfg);
            PHASE_CODE_EXTLEN: word = 64'(ext_len_cfg);
            PHASE_CODE_EXT:    word = 64'(ext_word_cfg);
            default:           word = 64'(size_cfg);
        endcase
        if (sh > 63)
            return 1'b0;
        return word[int'(sh)];
    endfunction

    // Expected result beat for one accepted item; advances the shadow state.
    function automatic result_t embed_step(logic kind, logic [7:0] cb, logic [7:0] sb);
        result_t    r;
        logic [2:0] k;
        r = '0;
        skip_done_phases();
        r.phase_now = frame_phase;
        if (kind == KIND_SECRET)
        begin
            if (held_full)
                r.status = STATUS_DROPPED;
            else
            begin
                held_secret = sb;
                held_full   = 1'b1;
            end
        end
        else
        begin
            r.byte_valid = 1'b1;
            if (frame_phase == PHASE_CODE_HEADER || frame_phase == PHASE_CODE_TAIL)
            begin
                r.out_byte = cb;
                if (frame_phase == PHASE_CODE_HEADER)
                    frame_pos++;
            end
            else if (frame_phase == PHASE_CODE_DATA)
            begin
                if (!held_full)
                begin
                    // No secret byte on hand: pass through and hold position.
                    r.out_byte = cb;
                    r.status   = STATUS_STARVED;
                end
                else
                begin
                    k          = frame_pos[2:0];
                    r.out_byte = {cb[7:1], held_secret[3'd7 - k]};
                    frame_pos++;
                    if (frame_pos[2:0] == 3'd0)
                        held_full = 1'b0;
                end
            end
            else
            begin
                r.out_byte = {cb[7:1], frame_bit(frame_phase, frame_pos)};
                frame_pos++;
            end
            skip_done_phases();
        end
        r.payload_done = (frame_phase == PHASE_CODE_TAIL);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    // Item side: predict on every accepted beat.
    always @(posedge clk)
    begin
        if (rst_n && item_bus.valid && item_bus.ready)
        begin
            image_out_q.push_back(embed_step(item_bus.kind, item_bus.carrier_byte,
                                             item_bus.secret_byte));
            item_taken <= 1'b1;
        end
        else
            item_taken <= 1'b0;
    end

    // Item side: drive the next beat once the previous one has gone.
    always @(negedge clk)
    begin
        item_t beat;
        if (!rst_n)
            item_bus.valid <= 1'b0;
        else if (!item_bus.valid || item_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_bus.valid <= 1'b0;
            end
            else if (stream_in_q.size() != 0)
            begin
                beat = stream_in_q.pop_front();
                item_bus.kind         <= beat.kind;
                item_bus.carrier_byte <= beat.carrier_byte;
                item_bus.secret_byte  <= beat.secret_byte;
                item_bus.valid        <= 1'b1;
                send_gap = pick_gap();
            end
            else
                item_bus.valid <= 1'b0;
        end
    end

    // Result side: random stalls plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left   = 80;
            result_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            result_bus.ready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    // Result side: compare each accepted beat with the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (image_out_q.size() == 0)
            begin
                $error("result beat with no prediction pending");
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = image_out_q.pop_front();
                check_field("out_byte", want.out_byte, result_bus.out_byte);
                check_field("byte_valid", want.byte_valid, result_bus.byte_valid);
                check_field("phase_now", want.phase_now, result_bus.phase_now);
                check_field("status", want.status, result_bus.status);
                check_field("payload_done", want.payload_done, result_bus.payload_done);
            end
        end
    end

    task automatic push_item(logic kind, logic [7:0] cb, logic [7:0] sb);
        item_t beat;
        while (stream_in_q.size() != 0)
            @(posedge clk);
        beat.kind         = kind;
        beat.carrier_byte = cb;
        beat.secret_byte  = sb;
        stream_in_q.push_back(beat);
    endtask

    // Random items; in the data phase loads mostly arrive once per eight carriers.
    task automatic random_items(int count);
        logic kind;
        bit   last_load;
        last_load = 1'b0;
        repeat (count)
        begin
            if (frame_phase == PHASE_CODE_DATA)
            begin
                if (held_full || last_load)
                    kind = ($urandom_range(0, 19) == 0);
                else
                    kind = ($urandom_range(0, 4) != 0);
            end
            else
                kind = ($urandom_range(0, 11) == 0);
            last_load = kind;
            push_item(kind, 8'($urandom()), 8'($urandom()));
        end
    endtask

    // Wait until nothing is in flight, then let the pipeline settle.
    task automatic drain();
        while (stream_in_q.size() != 0 || item_bus.valid || image_out_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [55:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_MAGIC_WORD:  magic_cfg    = value[15:0];
            CFG_EXT_LEN:     ext_len_cfg  = value[2:0];
            CFG_EXT_WORD:    ext_word_cfg = value;
            CFG_SECRET_SIZE: size_cfg     = value[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus: one frame walked through several register settings.
    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        item_bus.valid        = 1'b0;
        item_bus.kind         = KIND_CARRIER;
        item_bus.carrier_byte = '0;
        item_bus.secret_byte  = '0;
        result_bus.ready      = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: a held load, a dropped load, and header bytes at the extremes.
        push_item(KIND_SECRET, 8'h00, 8'hFF);
        push_item(KIND_SECRET, 8'hFF, 8'h00);
        push_item(KIND_CARRIER, 8'h00, 8'h00);
        push_item(KIND_CARRIER, 8'hFF, 8'hFF);
        push_item(KIND_CARRIER, 8'h01, 8'h00);
        push_item(KIND_CARRIER, 8'hFE, 8'h00);
        push_item(KIND_CARRIER, 8'h80, 8'h00);
        push_item(KIND_CARRIER, 8'h7F, 8'h00);
        push_item(KIND_CARRIER, 8'hAA, 8'h00);
        push_item(KIND_CARRIER, 8'h55, 8'h00);
        drain();

        // All-ones registers, no idling: through the header into the magic field.
        write_reg(CFG_MAGIC_WORD, 56'hFFFF);
        write_reg(CFG_EXT_LEN, 56'd7);
        write_reg(CFG_EXT_WORD, {56{1'b1}});
        write_reg(CFG_SECRET_SIZE, 56'hFFFF_FFFF);
        steady = 1'b1;
        random_items(60);
        drain();

        // Random words, with a long result stall so the input backs up.
        steady = 1'b0;
        write_reg(CFG_MAGIC_WORD, 56'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_EXT_WORD, {24'($urandom()), 32'($urandom())});
        hold_asked++;
        random_items(80);
        drain();

        // Shrink the extension so it ends early or is skipped.
        write_reg(CFG_EXT_LEN, 56'($urandom_range(0, 2)));
        write_reg(CFG_EXT_WORD, {24'($urandom()), 32'($urandom())});
        random_items(80);
        drain();

        // Large random size keeps the data phase open.
        write_reg(CFG_SECRET_SIZE, 56'(32'($urandom()) | 32'h8000_0000));
        random_items(110);
        drain();

        // Size set just past the bytes done, so the data phase ends on its own.
        write_reg(CFG_SECRET_SIZE, 56'(32'(frame_pos >> 3) + 32'd2));
        steady = 1'b1;
        random_items(30);
        steady = 1'b0;
        random_items(70);
        drain();

        // All-zero registers while in the tail: bytes keep passing through.
        write_reg(CFG_MAGIC_WORD, 56'h0);
        write_reg(CFG_EXT_LEN, 56'd0);
        write_reg(CFG_EXT_WORD, 56'h0);
        write_reg(CFG_SECRET_SIZE, 56'h0);
        random_items(70);
        drain();
        repeat (8) @(posedge clk);

        if (!mismatch_seen && image_out_q.size() == 0)
            $display("PASS lsb_stego_embedder_unit");
        else
            $display("FAIL lsb_stego_embedder_unit");
        $finish;
    end

endmodule
